// ===== src/chunked_voxel_store_with_dirty_queue_macros.svh =====
// Assertion macros for the voxel store checker
`ifndef CHUNKED_VOXEL_STORE_WITH_DIRTY_QUEUE_MACROS_SVH
`define CHUNKED_VOXEL_STORE_WITH_DIRTY_QUEUE_MACROS_SVH
// implication checked every cycle outside reset
`define CVS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/cvs_pkg.sv =====
// Shared types and constants for the chunked voxel store
package cvs_pkg;
    localparam int CHUNK_SIDE_DEF = 16;
    localparam int MAX_CHUNKS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int KEY_OUT_BITS   = 12;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_POP   = 2'd2;

    // broadcast along the directory chain
    typedef struct packed {
        logic        lookup;
        logic        pop;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [7:0]  pop_slot;
    } cvs_bcast_t;
endpackage

// ===== src/cvs_cell.sv =====
// One directory slot: key, used and dirty flags; passes hit/free info down the chain
module cvs_cell #(
    parameter int KEY_BITS = 12,
    parameter int SLOT_BITS = 4,
    parameter int SLOT_ID = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cvs_pkg::cvs_bcast_t   bc,
    input  logic                  hit_in,
    input  logic [SLOT_BITS-1:0]  hit_slot_in,
    input  logic                  free_in,
    input  logic [SLOT_BITS-1:0]  free_slot_in,
    input  logic                  alloc_en,
    input  logic [SLOT_BITS-1:0]  alloc_slot,
    input  logic                  dirty_set,
    input  logic [SLOT_BITS-1:0]  dirty_slot,
    output logic                  hit_out,
    output logic [SLOT_BITS-1:0]  hit_slot_out,
    output logic                  free_out,
    output logic [SLOT_BITS-1:0]  free_slot_out,
    output logic                  dirty,
    output logic [3*KEY_BITS-1:0] key
);
    logic used_reg;
    logic dirty_reg;
    logic [3*KEY_BITS-1:0] key_reg;
    logic match;
    localparam logic [SLOT_BITS-1:0] ME = SLOT_BITS'(SLOT_ID);

    assign match = used_reg && key_reg == {bc.kx[KEY_BITS-1:0], bc.ky[KEY_BITS-1:0],
                                           bc.kz[KEY_BITS-1:0]};
    assign hit_out       = hit_in || match;
    assign hit_slot_out  = hit_in ? hit_slot_in : ME;
    assign free_out      = free_in || !used_reg;
    assign free_slot_out = free_in ? free_slot_in : ME;
    assign dirty = dirty_reg;
    assign key   = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            if (alloc_en && alloc_slot == ME)
                used_reg <= 1'b1;
            if (dirty_set && dirty_slot == ME)
                dirty_reg <= 1'b1;
            else if (bc.pop && bc.pop_slot[SLOT_BITS-1:0] == ME)
                dirty_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_en && alloc_slot == ME)
            key_reg <= {bc.kx[KEY_BITS-1:0], bc.ky[KEY_BITS-1:0], bc.kz[KEY_BITS-1:0]};
    end
endmodule

// ===== src/cvs_store.sv =====
// Voxel byte memory with a clearing sweep after reset
module cvs_store #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [7:0]           wdata,
    output logic [7:0]           rdata,
    output logic                 busy
);
    logic [7:0] mem [2**ADDR_BITS];
    logic [ADDR_BITS:0] clr_reg;

    assign busy = !clr_reg[ADDR_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (busy)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (busy)
            mem[clr_reg[ADDR_BITS-1:0]] <= 8'd0;
        else if (wr_en)
            mem[addr] <= wdata;
        if (rd_en)
            rdata <= mem[addr];
    end
endmodule

// ===== src/chunked_voxel_store_with_dirty_queue.sv =====
// Chunked voxel store: directory chain, dirty FIFO and voxel memory
// Request path: the request is latched, the directory chain resolves and the memory is
// accessed, and the result is registered. No new request is taken while one is latched,
// during the reset sweep or while a stalled result is held; one is taken in the cycle the result leaves.
// Reset: flags and FIFO clear at once; the voxel memory, 2**ADDR_BITS bytes
// (MAX_CHUNKS rounded up to a power of two, times CHUNK_SIDE^3), is then swept to zero.
module chunked_voxel_store_with_dirty_queue #(
    parameter int CHUNK_SIDE = cvs_pkg::CHUNK_SIDE_DEF,
    parameter int MAX_CHUNKS = cvs_pkg::MAX_CHUNKS_DEF,
    parameter int COORD_BITS = cvs_pkg::COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] pos_z,
    input  logic [7:0]  block_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_value,
    output logic        popped_valid,
    output logic [11:0] chunk_key_x,
    output logic [11:0] chunk_key_y,
    output logic [11:0] chunk_key_z,
    output logic        status
);
    // CHUNK_SIDE is a power of two, so split is a shift and a mask
    localparam int OFF_BITS  = $clog2(CHUNK_SIDE);
    localparam int SLOT_BITS = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_CHUNKS + 1);
    localparam int KEY_BITS  = (COORD_BITS - OFF_BITS > 0) ? COORD_BITS - OFF_BITS : 1;
    localparam int ADDR_BITS = SLOT_BITS + 3 * OFF_BITS;

    // pipeline state: stage 1 = request latched, stage 2 = result pending
    logic        s1_reg;
    logic [1:0]  req_reg;
    logic [15:0] px_reg, py_reg, pz_reg;
    logic [7:0]  val_reg;
    logic        busy;

    // a request is taken when the sweep is done and nothing is in flight or the pending result leaves now
    assign in_stall = busy || s1_reg || (out_valid && out_stall);

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= req_type;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            val_reg <= block_value;
        end
    end

    logic [COORD_BITS-1:0] cx, cy, cz;
    assign cx = COORD_BITS'(px_reg);
    assign cy = COORD_BITS'(py_reg);
    assign cz = COORD_BITS'(pz_reg);

    // dirty FIFO
    logic [SLOT_BITS-1:0] fifo_mem [MAX_CHUNKS];
    logic [SLOT_BITS-1:0] head_reg, tail_reg;
    logic [CNT_BITS-1:0]  count_reg;

    cvs_pkg::cvs_bcast_t bc;
    logic is_acc, is_pop;
    assign is_acc = s1_reg && (req_reg == cvs_pkg::REQ_READ || req_reg == cvs_pkg::REQ_WRITE);
    assign is_pop = s1_reg && req_reg == cvs_pkg::REQ_POP && count_reg != '0;

    always_comb
    begin
        bc = '0;
        bc.lookup = is_acc;
        bc.pop    = is_pop;
        bc.kx = 32'(cx >> OFF_BITS);
        bc.ky = 32'(cy >> OFF_BITS);
        bc.kz = 32'(cz >> OFF_BITS);
        bc.pop_slot = 8'(fifo_mem[head_reg]);
    end

    // directory chain
    logic                 hit_c  [MAX_CHUNKS+1];
    logic [SLOT_BITS-1:0] hslot_c[MAX_CHUNKS+1];
    logic                 free_c [MAX_CHUNKS+1];
    logic [SLOT_BITS-1:0] fslot_c[MAX_CHUNKS+1];
    logic                 dirty_v[MAX_CHUNKS];
    logic [3*KEY_BITS-1:0] key_v [MAX_CHUNKS];
    logic alloc_en, dirty_set;
    logic [SLOT_BITS-1:0] slot;

    assign hit_c[0] = 1'b0;
    assign hslot_c[0] = '0;
    assign free_c[0] = 1'b0;
    assign fslot_c[0] = '0;

    for (genvar i = 0; i < MAX_CHUNKS; i++)
    begin : g_cell
        cvs_cell #(.KEY_BITS(KEY_BITS), .SLOT_BITS(SLOT_BITS), .SLOT_ID(i)) u_cell (
            .clk(clk), .rst_n(rst_n), .bc(bc),
            .hit_in(hit_c[i]), .hit_slot_in(hslot_c[i]),
            .free_in(free_c[i]), .free_slot_in(fslot_c[i]),
            .alloc_en(alloc_en), .alloc_slot(slot),
            .dirty_set(dirty_set), .dirty_slot(slot),
            .hit_out(hit_c[i+1]), .hit_slot_out(hslot_c[i+1]),
            .free_out(free_c[i+1]), .free_slot_out(fslot_c[i+1]),
            .dirty(dirty_v[i]), .key(key_v[i])
        );
    end

    logic hit, full, slot_dirty;
    assign hit  = hit_c[MAX_CHUNKS];
    assign full = !hit && !free_c[MAX_CHUNKS];
    assign slot = hit ? hslot_c[MAX_CHUNKS] : fslot_c[MAX_CHUNKS];
    assign slot_dirty = hit ? dirty_v[slot] : 1'b0;
    assign alloc_en  = is_acc && !hit && !full;
    // a new chunk or a write to a clean chunk queues it
    assign dirty_set = is_acc && !full && !slot_dirty &&
                       (!hit || req_reg == cvs_pkg::REQ_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (dirty_set)
                tail_reg <= (32'(tail_reg) + 1 >= MAX_CHUNKS) ? '0 : tail_reg + 1'b1;
            if (is_pop)
                head_reg <= (32'(head_reg) + 1 >= MAX_CHUNKS) ? '0 : head_reg + 1'b1;
            if (dirty_set && !is_pop)
                count_reg <= count_reg + 1'b1;
            else if (is_pop && !dirty_set)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dirty_set)
            fifo_mem[tail_reg] <= slot;
    end

    // voxel memory
    logic [ADDR_BITS-1:0] addr;
    logic [7:0] rdata;
    assign addr = {slot, cz[OFF_BITS-1:0], cy[OFF_BITS-1:0], cx[OFF_BITS-1:0]};

    cvs_store #(.ADDR_BITS(ADDR_BITS)) u_store (
        .clk(clk), .rst_n(rst_n),
        .rd_en(is_acc && !full && req_reg == cvs_pkg::REQ_READ),
        .wr_en(is_acc && !full && req_reg == cvs_pkg::REQ_WRITE),
        .addr(addr), .wdata(val_reg), .rdata(rdata), .busy(busy)
    );

    // result register; the read byte is registered in the memory alongside it
    logic       rd_sel_reg;
    logic       pv_reg, st_reg;
    logic [11:0] kx_reg, ky_reg, kz_reg;
    logic [3*KEY_BITS-1:0] pkey;
    assign pkey = key_v[fifo_mem[head_reg]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_reg <= 1'b1;
            else if (s1_reg)
                s1_reg <= 1'b0;
            if (s1_reg)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg)
        begin
            rd_sel_reg <= is_acc && !full && req_reg == cvs_pkg::REQ_READ;
            st_reg <= is_acc && full;
            pv_reg <= is_pop;
            kx_reg <= is_pop ? 12'(pkey[3*KEY_BITS-1:2*KEY_BITS]) : 12'd0;
            ky_reg <= is_pop ? 12'(pkey[2*KEY_BITS-1:KEY_BITS]) : 12'd0;
            kz_reg <= is_pop ? 12'(pkey[KEY_BITS-1:0]) : 12'd0;
        end
    end

    assign read_value   = rd_sel_reg ? rdata : 8'd0;
    assign popped_valid = pv_reg;
    assign chunk_key_x  = kx_reg;
    assign chunk_key_y  = ky_reg;
    assign chunk_key_z  = kz_reg;
    assign status       = st_reg;
endmodule

// ===== src/cvs_checker.sv =====
// Port-level checker for the voxel store, bound to the top level
`include "chunked_voxel_store_with_dirty_queue_macros.svh"
module cvs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       popped_valid,
    input logic       status,
    input logic [7:0] read_value,
    input logic [11:0] chunk_key_x
)
;
    `CVS_ASSERT_IMPL(a_pop_ok, clk, rst_n, out_valid && popped_valid, !status && read_value == 8'd0, "pop result carries read data or status")
    `CVS_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && status, read_value == 8'd0, "refused access returned data")
    `CVS_ASSERT_IMPL(a_key_zero, clk, rst_n, out_valid && !popped_valid, chunk_key_x == 12'd0, "key without pop")
    `CVS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall, "second request taken while busy")
    `CVS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_value), "stalled result changed")
endmodule

bind chunked_voxel_store_with_dirty_queue cvs_checker u_cvs_checker (.*);

// ===== test/tb_chunked_voxel_store_with_dirty_queue.sv =====
// Testbench for the chunked voxel store: queued driver, clocked monitor, built-in predictor
module tb_chunked_voxel_store_with_dirty_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = 16;
    localparam int SLOTS = 16;
    localparam int SLOT_BYTES = SIDE * SIDE * SIDE;
    // reset sweep of the voxel memory is the longest quiet stretch; keep well above it
    localparam int IDLE_LIMIT = 4 * SLOTS * SLOT_BYTES;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [7:0]  val;
    } voxel_req_t;

    typedef struct packed {
        logic [7:0]  rd;
        logic        popped;
        logic [11:0] kx;
        logic [11:0] ky;
        logic [11:0] kz;
        logic        st;
    } voxel_rsp_t;

    logic clk, rst_n;
    logic in_valid, in_stall;
    logic [1:0] req_type;
    logic [15:0] pos_x, pos_y, pos_z;
    logic [7:0] block_value;
    logic out_valid, out_stall;
    logic [7:0] read_value;
    logic popped_valid;
    logic [11:0] chunk_key_x, chunk_key_y, chunk_key_z;
    logic status;

    chunked_voxel_store_with_dirty_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .block_value(block_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_value(read_value), .popped_valid(popped_valid),
        .chunk_key_x(chunk_key_x), .chunk_key_y(chunk_key_y),
        .chunk_key_z(chunk_key_z), .status(status)
    );

    // shadow copy of the block's state
    bit          sh_used[SLOTS];
    bit          sh_dirty[SLOTS];
    logic [11:0] sh_key[SLOTS][3];
    logic [7:0]  sh_vox[SLOTS * SLOT_BYTES];
    int          sh_fifo[SLOTS];
    int          sh_head, sh_tail, sh_count;

    voxel_req_t pending_words[$];
    voxel_rsp_t expected_words[$];
    int fail_count;
    int idle_cycles;
    bit stim_done;

    function automatic void add_pending(voxel_req_t r);
        pending_words = {pending_words, r};
    endfunction

    function automatic void queue_dirty(int s);
        if (!sh_dirty[s] && sh_count < SLOTS)
        begin
            sh_fifo[sh_tail] = s;
            sh_tail = (sh_tail + 1) % SLOTS;
            sh_count++;
            sh_dirty[s] = 1;
        end
    endfunction

    function automatic int lookup_chunk(logic [11:0] kx, logic [11:0] ky, logic [11:0] kz);
        for (int i = 0; i < SLOTS; i++)
            if (sh_used[i] && sh_key[i][0] == kx && sh_key[i][1] == ky && sh_key[i][2] == kz)
                return i;
        for (int i = 0; i < SLOTS; i++)
            if (!sh_used[i])
            begin
                sh_used[i] = 1;
                sh_key[i][0] = kx;
                sh_key[i][1] = ky;
                sh_key[i][2] = kz;
                sh_dirty[i] = 0;
                queue_dirty(i);
                return i;
            end
        return -1;
    endfunction

    // compute the response of one accepted request and update the shadow
    function automatic voxel_rsp_t voxel_response(voxel_req_t r);
        voxel_rsp_t o;
        int s, addr;
        o = '0;
        if (r.req == cvs_pkg::REQ_READ || r.req == cvs_pkg::REQ_WRITE)
        begin
            s = lookup_chunk(r.x[15:4], r.y[15:4], r.z[15:4]);
            if (s < 0)
                o.st = 1;
            else
            begin
                addr = s * SLOT_BYTES + r.x[3:0] + (r.y[3:0] + r.z[3:0] * SIDE) * SIDE;
                if (r.req == cvs_pkg::REQ_WRITE)
                begin
                    queue_dirty(s);
                    sh_vox[addr] = r.val;
                end
                else
                    o.rd = sh_vox[addr];
            end
        end
        else if (r.req == cvs_pkg::REQ_POP && sh_count > 0)
        begin
            s = sh_fifo[sh_head];
            sh_head = (sh_head + 1) % SLOTS;
            sh_count--;
            sh_dirty[s] = 0;
            o.popped = 1;
            o.kx = sh_key[s][0];
            o.ky = sh_key[s][1];
            o.kz = sh_key[s][2];
        end
        return o;
    endfunction

    function automatic voxel_req_t make_req(logic [1:0] t, logic [15:0] x, logic [15:0] y,
                                            logic [15:0] z, logic [7:0] v);
        voxel_req_t r;
        r.req = t; r.x = x; r.y = y; r.z = z; r.val = v;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    // stimulus
    initial
    begin
        logic [15:0] bx[12], by[12], bz[12];
        logic [1:0] t;
        int k, n;
        for (int i = 0; i < SLOTS * SLOT_BYTES; i++) sh_vox[i] = 0;
        // directed: extremes, new-chunk reads, write/readback, pops, spare code
        add_pending(make_req(cvs_pkg::REQ_POP, 16'h0, 16'h0, 16'h0, 8'h0));
        add_pending(make_req(cvs_pkg::REQ_READ, 16'h0, 16'h0, 16'h0, 8'h0));
        add_pending(make_req(cvs_pkg::REQ_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        add_pending(make_req(cvs_pkg::REQ_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h0));
        add_pending(make_req(cvs_pkg::REQ_WRITE, 16'h0010, 16'hFFF0, 16'h000F, 8'h5A));
        add_pending(make_req(cvs_pkg::REQ_READ, 16'h0010, 16'hFFF0, 16'h000F, 8'h0));
        add_pending(make_req(REQ_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        add_pending(make_req(cvs_pkg::REQ_POP, 16'h0, 16'h0, 16'h0, 8'h0));
        add_pending(make_req(cvs_pkg::REQ_POP, 16'h0, 16'h0, 16'h0, 8'h0));
        add_pending(make_req(cvs_pkg::REQ_POP, 16'h0, 16'h0, 16'h0, 8'h0));
        add_pending(make_req(cvs_pkg::REQ_POP, 16'h0, 16'h0, 16'h0, 8'h0));
        // fill the directory, then miss with a full directory
        for (int i = 0; i < 14; i++)
            add_pending(make_req(cvs_pkg::REQ_WRITE, 16'(i * 16), 16'h1234, 16'h8000,
                                 8'(i)));
        add_pending(make_req(cvs_pkg::REQ_WRITE, 16'hABCD, 16'h4321, 16'h7777, 8'h11));
        add_pending(make_req(cvs_pkg::REQ_READ, 16'hABCD, 16'h4321, 16'h7777, 8'h00));
        // random: mostly hits in the resident chunks, some misses/noise
        for (int i = 0; i < 12; i++)
        begin
            if (i < 3)
            begin
                bx[i] = (i == 1) ? 16'hFFF0 : 16'h0000;
                by[i] = 16'h0000;
                bz[i] = 16'h0000;
            end
            else
            begin
                bx[i] = 16'((i - 3) * 16);
                by[i] = 16'h1234;
                bz[i] = 16'h8000;
            end
        end
        n = 0;
        while (n < 1800)
        begin
            k = $urandom_range(0, 11);
            t = $urandom_range(0, 99) < 45 ? cvs_pkg::REQ_WRITE :
                ($urandom_range(0, 99) < 70 ? cvs_pkg::REQ_READ :
                ($urandom_range(0, 9) < 9 ? cvs_pkg::REQ_POP : REQ_SPARE));
            if ($urandom_range(0, 9) == 0)
                add_pending(make_req(t, 16'($urandom), 16'($urandom), 16'($urandom),
                                     8'($urandom)));
            else
                add_pending(make_req(t, {bx[k][15:4], 4'($urandom)},
                    {by[k][15:4], 4'($urandom)}, {bz[k][15:4], 4'($urandom)}, 8'($urandom)));
            n++;
        end
        stim_done = 1;
    end

    // driver: bursts and gaps
    int gap_left, burst_left;
    voxel_req_t cur_word;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            req_type <= '0; pos_x <= '0; pos_y <= '0; pos_z <= '0; block_value <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_words = {expected_words, voxel_response(cur_word)};
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 0;
            end
            else if (pending_words.size() > 0)
            begin
                cur_word = pending_words.pop_front();
                in_valid <= 1;
                req_type <= cur_word.req;
                pos_x <= cur_word.x;
                pos_y <= cur_word.y;
                pos_z <= cur_word.z;
                block_value <= cur_word.val;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
            else
                in_valid <= 0;
        end
    end

    // receiver stall pattern: alternating free runs and random stalling
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[7:6] == 2'd0)
                out_stall <= 0;
            else if (stall_phase[7:6] == 2'd1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // monitor
    voxel_rsp_t got, want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = {read_value, popped_valid, chunk_key_x, chunk_key_y, chunk_key_z, status};
            if (expected_words.size() == 0)
            begin
                $display("%t: unexpected word, actual %h", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.rd !== want.rd)
                begin
                    $display("%t: read_value exp %h act %h", $realtime, want.rd, got.rd);
                    fail_count++;
                end
                if (got.popped !== want.popped)
                begin
                    $display("%t: popped_valid exp %h act %h", $realtime, want.popped, got.popped);
                    fail_count++;
                end
                if (got.kx !== want.kx)
                begin
                    $display("%t: chunk_key_x exp %h act %h", $realtime, want.kx, got.kx);
                    fail_count++;
                end
                if (got.ky !== want.ky)
                begin
                    $display("%t: chunk_key_y exp %h act %h", $realtime, want.ky, got.ky);
                    fail_count++;
                end
                if (got.kz !== want.kz)
                begin
                    $display("%t: chunk_key_z exp %h act %h", $realtime, want.kz, got.kz);
                    fail_count++;
                end
                if (got.st !== want.st)
                begin
                    $display("%t: status exp %h act %h", $realtime, want.st, got.st);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_chunked_voxel_store_with_dirty_queue: FAIL");
            $finish;
        end
    end

    // end of run
    initial
    begin
        fail_count = 0;
        idle_cycles = 0;
        wait (stim_done);
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (in_valid) @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_chunked_voxel_store_with_dirty_queue: PASS");
        else
            $display("tb_chunked_voxel_store_with_dirty_queue: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/cvs_pkg.sv
src/cvs_cell.sv
src/cvs_store.sv
src/chunked_voxel_store_with_dirty_queue.sv
src/cvs_checker.sv
test/tb_chunked_voxel_store_with_dirty_queue.sv
